@@ hdl/dns_query_to_answer_rewriter_defines.svh @@
// Assertion helpers used by the rewriter output stage.
`ifndef DNS_QUERY_TO_ANSWER_REWRITER_DEFINES_SVH
`define DNS_QUERY_TO_ANSWER_REWRITER_DEFINES_SVH

// Check that holds in the same cycle as its trigger.
`define DNSR_ASSERT_NOW(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("%m: same-cycle check failed");

// Check that holds in the cycle after its trigger.
`define DNSR_ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("%m: next-cycle check failed");

`endif

@@ hdl/dnsr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package dnsr_pkg;

    localparam int MAX_MSG_BYTES = 512;
    localparam int OFS_W         = $clog2(MAX_MSG_BYTES + 1);

    localparam int BYTE_W        = 8;
    localparam int HASH_W        = 32;
    localparam int FLAGS_W       = 16;
    localparam int REC_BYTES     = 16;
    localparam int REC_IDX_W     = $clog2(REC_BYTES);

    localparam logic [15:0]       FLAGS_RESET = 16'h8180;
    localparam logic [BYTE_W-1:0] CHAR_DOT    = 8'h2E;

    // Header offsets that get rewritten, start of the question name, and offset cap
    localparam logic [OFS_W-1:0] OFS_FLAGS_HI = OFS_W'(2);
    localparam logic [OFS_W-1:0] OFS_FLAGS_LO = OFS_W'(3);
    localparam logic [OFS_W-1:0] OFS_ANCNT_HI = OFS_W'(6);
    localparam logic [OFS_W-1:0] OFS_ANCNT_LO = OFS_W'(7);
    localparam logic [OFS_W-1:0] OFS_NAME     = OFS_W'(12);
    localparam logic [OFS_W-1:0] OFS_MAX      = OFS_W'(MAX_MSG_BYTES);

    // APB map
    localparam int          APB_ADDR_W = 3;
    localparam logic        REG_FLAGS  = 1'b0;

    // Name walk phase, one-hot
    typedef enum logic [3:0] {
        PH_FIRST = 4'b0001,
        PH_LABEL = 4'b0010,
        PH_NEXT  = 4'b0100,
        PH_DONE  = 4'b1000
    } t_phase;

    // One response byte handed from the walker to the output stage
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              msg_end;
        logic [HASH_W-1:0] hash;
    } t_res;

    // h = c + 31*h, modulo 2^32
    function automatic logic [HASH_W-1:0] hash_in(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] c);
        hash_in = (h << 5) - h + {{(HASH_W-BYTE_W){1'b0}}, c};
    endfunction

    // Appended A record: C00C, type 1, class 1, TTL 300, rdlength 4, hash LSB first
    function automatic logic [BYTE_W-1:0] rec_byte(input logic [REC_IDX_W-1:0] idx,
                                                    input logic [HASH_W-1:0] h);
        case (idx)
            4'd0:    rec_byte = 8'hC0;
            4'd1:    rec_byte = 8'h0C;
            4'd3:    rec_byte = 8'h01;
            4'd5:    rec_byte = 8'h01;
            4'd8:    rec_byte = 8'h01;
            4'd9:    rec_byte = 8'h2C;
            4'd11:   rec_byte = 8'h04;
            4'd12:   rec_byte = h[7:0];
            4'd13:   rec_byte = h[15:8];
            4'd14:   rec_byte = h[23:16];
            4'd15:   rec_byte = h[31:24];
            default: rec_byte = 8'h00;
        endcase
    endfunction

endpackage
`default_nettype wire

@@ hdl/dnsr_walk.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dnsr_walk
    import dnsr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic [BYTE_W-1:0]  i_byte,
    input  wire logic               i_last,
    input  wire logic [FLAGS_W-1:0] i_flags,
    output t_res                    o_res
);

    logic [OFS_W-1:0]  r_ofs,   n_ofs;
    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_rem,   n_rem;
    logic [HASH_W-1:0] r_hash,  n_hash;
    logic [BYTE_W-1:0] w_ob;

    // Header rewrite
    always_comb begin
        w_ob = i_byte;
        if (r_ofs == OFS_FLAGS_HI) begin
            w_ob = i_flags[15:8];
        end else if (r_ofs == OFS_FLAGS_LO) begin
            w_ob = i_flags[7:0];
        end else if (r_ofs == OFS_ANCNT_HI) begin
            w_ob = 8'h00;
        end else if (r_ofs == OFS_ANCNT_LO) begin
            w_ob = 8'h01;
        end
    end

    // Question name walk
    always_comb begin
        n_phase = r_phase;
        n_rem   = r_rem;
        n_hash  = r_hash;
        if (r_ofs >= OFS_NAME) begin
            case (r_phase)
                PH_FIRST, PH_NEXT: begin
                    if (i_byte == '0) begin
                        n_phase = PH_DONE;
                    end else begin
                        if (r_phase == PH_NEXT) begin
                            n_hash = hash_in(r_hash, CHAR_DOT);
                        end
                        n_rem   = i_byte;
                        n_phase = PH_LABEL;
                    end
                end
                PH_LABEL: begin
                    n_hash = hash_in(r_hash, i_byte);
                    n_rem  = r_rem - 1'b1;
                    if (r_rem == BYTE_W'(1)) begin
                        n_phase = PH_NEXT;
                    end
                end
                default: begin
                end
            endcase
        end
        n_ofs = (r_ofs < OFS_MAX) ? r_ofs + 1'b1 : r_ofs;
    end

    assign o_res.data    = w_ob;
    assign o_res.msg_end = i_last;
    assign o_res.hash    = n_hash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ofs   <= '0;
            r_phase <= PH_FIRST;
            r_rem   <= '0;
            r_hash  <= '0;
        end else if (i_push) begin
            if (i_last) begin
                r_ofs   <= '0;
                r_phase <= PH_FIRST;
                r_rem   <= '0;
                r_hash  <= '0;
            end else begin
                r_ofs   <= n_ofs;
                r_phase <= n_phase;
                r_rem   <= n_rem;
                r_hash  <= n_hash;
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/dnsr_out.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "dns_query_to_answer_rewriter_defines.svh"
module dnsr_out
    import dnsr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire t_res              i_res,
    output logic                   o_push_ready,
    input  wire logic              i_tready,
    output logic                   o_tvalid,
    output logic [BYTE_W-1:0]      o_tdata,
    output logic                   o_tlast
);

    logic                 r_valid, n_valid;
    logic [BYTE_W-1:0]    r_data,  n_data;
    logic                 r_last,  n_last;
    logic                 r_busy,  n_busy;
    logic [REC_IDX_W-1:0] r_idx,   n_idx;
    logic [HASH_W-1:0]    r_hash,  n_hash;
    logic                 w_adv;

    // Result register frees up when empty or being taken
    assign w_adv        = !r_valid || i_tready;
    assign o_push_ready = w_adv && !r_busy;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        n_last  = r_last;
        n_busy  = r_busy;
        n_idx   = r_idx;
        n_hash  = r_hash;
        if (w_adv) begin
            if (r_busy) begin
                n_valid = 1'b1;
                n_data  = rec_byte(r_idx, r_hash);
                n_last  = (r_idx == REC_IDX_W'(REC_BYTES - 1));
                n_idx   = r_idx + 1'b1;
                n_busy  = !n_last;
            end else if (i_push) begin
                n_valid = 1'b1;
                n_data  = i_res.data;
                n_last  = 1'b0;
                if (i_res.msg_end) begin
                    n_busy = 1'b1;
                    n_idx  = '0;
                    n_hash = i_res.hash;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_busy  <= n_busy;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_last <= n_last;
        r_hash <= n_hash;
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tlast  = r_last;

    `DNSR_ASSERT_NOW(a_no_req_during_rec, i_clk, i_rst_n, r_busy, !o_push_ready)
    `DNSR_ASSERT_NEXT(a_end_starts_rec, i_clk, i_rst_n, i_push && o_push_ready && i_res.msg_end, r_busy && (r_idx == '0))
    `DNSR_ASSERT_NOW(a_last_ends_rec, i_clk, i_rst_n, r_valid && r_last, !r_busy)
    `DNSR_ASSERT_NEXT(a_rec_advances, i_clk, i_rst_n, r_busy && w_adv && (r_idx != '1), r_busy && (r_idx == $past(r_idx) + 1'b1))

endmodule
`default_nettype wire

@@ hdl/dns_query_to_answer_rewriter.sv @@
// A query byte appears on the master side in the cycle after it is accepted.
// One query byte per cycle while the master side takes bytes; after the last byte
// the slave holds tready low while the 16-byte record leaves the result register.
// Reset (synchronous, active low): clear offset, name walk and hash, empty the
// output register, and load the flags register with 0x8180.
`timescale 1ns / 1ps
`default_nettype none
module dns_query_to_answer_rewriter
    import dnsr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // query stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // [7:0] in_byte
    input  wire logic                  s_axis_tlast,
    // response stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [7:0]                 m_axis_tdata,   // [7:0] out_byte
    output logic                       m_axis_tlast,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    // Flags register, written over header bytes two and three
    logic [FLAGS_W-1:0] r_flags;
    logic               w_sel_flags;
    logic               w_push;
    t_res               w_res;

    assign pready      = 1'b1;
    assign w_sel_flags = (paddr[APB_ADDR_W-1:2] == REG_FLAGS);
    assign prdata      = w_sel_flags ? {{(32-FLAGS_W){1'b0}}, r_flags} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= FLAGS_RESET;
        end else if (psel && penable && pwrite && pready && w_sel_flags) begin
            r_flags <= pwdata[FLAGS_W-1:0];
        end
    end

    // Accept a request only when the result register can take its byte and no record is streaming
    assign w_push = s_axis_tvalid && s_axis_tready;

    // Header rewrite and name hash, updated on each accepted byte
    dnsr_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_flags (r_flags),
        .o_res   (w_res)
    );

    // Result register plus the 16-byte answer sequencer
    dnsr_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_res        (w_res),
        .o_push_ready (s_axis_tready),
        .i_tready     (m_axis_tready),
        .o_tvalid     (m_axis_tvalid),
        .o_tdata      (m_axis_tdata),
        .o_tlast      (m_axis_tlast)
    );

endmodule
`default_nettype wire

@@ tb/dnsr_checker.sv @@
`timescale 1ns / 1ps
module dnsr_checker
    import dnsr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // query side
    input  logic                  i_query_valid,
    input  logic                  i_query_ready,
    input  logic [7:0]            i_query_byte,   // [7:0] in_byte
    input  logic                  i_query_last,
    // response side
    input  logic                  i_resp_valid,
    input  logic                  i_resp_ready,
    input  logic [7:0]            i_resp_byte,    // [7:0] out_byte
    input  logic                  i_resp_last,
    // register port
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [31:0]           i_pwdata,
    input  logic [31:0]           i_prdata,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_checked
);

    localparam logic [APB_ADDR_W-1:0] FLAGS_ADDR = APB_ADDR_W'(4 * REG_FLAGS);
    localparam logic [HASH_W-1:0]     HASH_MULT  = 32'd31;
    localparam logic [15:0]           ANCOUNT    = 16'd1;

    // Fixed part of the answer record: name pointer, type A, class IN, TTL, rdlength
    localparam logic [15:0] ANS_PTR     = 16'hC00C;
    localparam logic [15:0] RR_TYPE_A   = 16'd1;
    localparam logic [15:0] RR_CLASS_IN = 16'd1;
    localparam logic [31:0] RR_TTL      = 32'd300;
    localparam logic [15:0] RR_RDLEN    = 16'd4;
    localparam int          FIXED_BYTES = REC_BYTES - 4;
    localparam logic [8*FIXED_BYTES-1:0] ANSWER_FIXED =
        {ANS_PTR, RR_TYPE_A, RR_CLASS_IN, RR_TTL, RR_RDLEN};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_resp_byte;

    t_resp_byte           resp_expected[$];
    logic [OFS_W-1:0]     msg_ofs;
    t_phase               walk_phase;
    logic [7:0]           chars_left;
    logic [HASH_W-1:0]    qname_hash;
    logic [FLAGS_W-1:0]   flags_copy;

    function automatic logic [HASH_W-1:0] fold_char(input logic [HASH_W-1:0] h,
                                                     input logic [7:0] c);
        return h * HASH_MULT + HASH_W'(c);
    endfunction

    task automatic clear_query();
        msg_ofs    = '0;
        walk_phase = PH_FIRST;
        chars_left = '0;
        qname_hash = '0;
    endtask

    task automatic walk_qname(input logic [7:0] b);
        case (walk_phase)
            PH_FIRST, PH_NEXT: begin
                if (b == 8'd0) begin
                    walk_phase = PH_DONE;
                end else begin
                    if (walk_phase == PH_NEXT) qname_hash = fold_char(qname_hash, CHAR_DOT);
                    chars_left = b;
                    walk_phase = PH_LABEL;
                end
            end
            PH_LABEL: begin
                qname_hash = fold_char(qname_hash, b);
                chars_left = chars_left - 8'd1;
                if (chars_left == 8'd0) walk_phase = PH_NEXT;
            end
            default: ;
        endcase
    endtask

    task automatic predict_response(input logic [7:0] b, input logic last);
        logic [7:0] ob;
        int         k;
        ob = b;
        case (msg_ofs)
            OFS_FLAGS_HI: ob = flags_copy[15:8];
            OFS_FLAGS_LO: ob = flags_copy[7:0];
            OFS_ANCNT_HI: ob = ANCOUNT[15:8];
            OFS_ANCNT_LO: ob = ANCOUNT[7:0];
            default: ;
        endcase
        if (msg_ofs >= OFS_NAME) walk_qname(b);
        resp_expected.push_back('{data: ob, last: 1'b0});
        if (msg_ofs < OFS_MAX) msg_ofs = msg_ofs + 1'b1;
        if (last) begin
            for (k = 0; k < FIXED_BYTES; k++)
                resp_expected.push_back('{data: ANSWER_FIXED[8*(FIXED_BYTES-1-k) +: 8],
                                          last: 1'b0});
            // address bytes carry the hash, low byte first
            for (k = 0; k < 4; k++)
                resp_expected.push_back('{data: qname_hash[8*k +: 8], last: (k == 3)});
            clear_query();
        end
    endtask

    always @(posedge i_clk) begin
        t_resp_byte want;
        if (!i_rst_n) begin
            clear_query();
            flags_copy = FLAGS_RESET;
            resp_expected.delete();
        end else begin
            if (i_resp_valid && i_resp_ready) begin
                if (resp_expected.size() == 0) begin
                    $error("response byte %02h with nothing expected", i_resp_byte);
                    o_errors++;
                end else begin
                    want = resp_expected.pop_front();
                    o_checked++;
                    if (i_resp_byte !== want.data) begin
                        $error("out_byte: expected %02h, actual %02h", want.data, i_resp_byte);
                        o_errors++;
                    end
                    if (i_resp_last !== want.last) begin
                        $error("out_last: expected %0b, actual %0b", want.last, i_resp_last);
                        o_errors++;
                    end
                end
            end
            if (i_query_valid && i_query_ready) predict_response(i_query_byte, i_query_last);
            if (i_psel && i_penable && i_pready && i_paddr == FLAGS_ADDR) begin
                if (i_pwrite) begin
                    flags_copy = i_pwdata[FLAGS_W-1:0];
                end else if (i_prdata[FLAGS_W-1:0] !== flags_copy) begin
                    $error("response_flags: expected %04h, actual %04h",
                           flags_copy, i_prdata[FLAGS_W-1:0]);
                    o_errors++;
                end
            end
        end
        o_pending = resp_expected.size();
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import dnsr_pkg::*;

    // Register map: the flags word is register 0
    localparam logic [APB_ADDR_W-1:0] FLAGS_ADDR = APB_ADDR_W'(4 * REG_FLAGS);
    // Worst case, every byte ending a query under the longest stalls, stays
    // under 100 us; allow several times that
    localparam int TIMEOUT_NS = 400_000;
    // Minimum query bytes per random phase
    localparam int PHASE_BYTES = 16;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;   // [7:0] in_byte
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [7:0]            m_axis_tdata;   // [7:0] out_byte
    logic                  m_axis_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int         fail_count;
    int         resp_pending;
    int         resp_checked;
    int         n_queries;
    int         n_query_bytes;
    logic       stalls_on = 1'b1;   // random idling on both sides while set
    logic [7:0] msg_buf[$];         // query under construction

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    dns_query_to_answer_rewriter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    dnsr_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_query_valid (s_axis_tvalid),
        .i_query_ready (s_axis_tready),
        .i_query_byte  (s_axis_tdata),
        .i_query_last  (s_axis_tlast),
        .i_resp_valid  (m_axis_tvalid),
        .i_resp_ready  (m_axis_tready),
        .i_resp_byte   (m_axis_tdata),
        .i_resp_last   (m_axis_tlast),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .o_errors      (fail_count),
        .o_pending     (resp_pending),
        .o_checked     (resp_checked)
    );

    // Hard stop in case the block hangs
    initial begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    // Response sink: alternate ready stretches with random stall bursts.
    // Every change happens at a new falling edge, so ready never glitches.
    initial begin
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (stalls_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge i_clk);
        end
    end

    // Offer one query byte and hold it until the block takes it.
    // Enter and leave at a falling edge; valid stays high for a following byte.
    task automatic put_byte(input logic [7:0] b, input logic last);
        if (stalls_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Send the buffered query, marking its final byte
    task automatic send_msg();
        int i;
        for (i = 0; i < msg_buf.size(); i++) put_byte(msg_buf[i], i == msg_buf.size() - 1);
        n_queries++;
        n_query_bytes += msg_buf.size();
        msg_buf.delete();
    endtask

    task automatic add_header();
        repeat (12) msg_buf.push_back(8'($urandom));
    endtask

    // Push a length byte, then that many random characters (fewer for a cut name)
    task automatic add_label(input logic [7:0] len, input int nchars);
        msg_buf.push_back(len);
        repeat (nchars) msg_buf.push_back(8'($urandom));
    endtask

    // Drop valid, let every expected response drain, then pause for the pipeline
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (resp_pending != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // One register access: setup cycle, then access cycle until pready
    task automatic flags_access(input logic wr, input logic [31:0] wdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= FLAGS_ADDR;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Write the flags word with junk in the unused upper bits, then read it back
    task automatic set_flags(input logic [15:0] value);
        flags_access(1'b1, {16'($urandom), value});
        flags_access(1'b0, 32'd0);
    endtask

    // Mostly well-formed queries with random content; the rest short,
    // cut inside the name, or plain noise after the header
    task automatic rand_query();
        int kind;
        int n;
        int len;
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            add_header();
            n = $urandom_range(0, 3);
            repeat (n) begin
                len = $urandom_range(1, 6);
                add_label(8'(len), len);
            end
            msg_buf.push_back(8'h00);
            repeat (4) msg_buf.push_back(8'($urandom));
        end else if (kind == 7) begin
            repeat ($urandom_range(1, 11)) msg_buf.push_back(8'($urandom));
        end else if (kind == 8) begin
            add_header();
            len = $urandom_range(2, 8);
            add_label(8'(len), $urandom_range(0, len - 1));
        end else begin
            add_header();
            repeat ($urandom_range(1, 10)) msg_buf.push_back(8'($urandom));
        end
        send_msg();
    endtask

    task automatic rand_phase();
        int target;
        target = n_query_bytes + PHASE_BYTES;
        while (n_query_bytes < target) rand_query();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = 32'd0;
        n_queries     = 0;
        n_query_bytes = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, flags at their reset value.
        // One-byte query: last byte at offset zero, record with an empty hash
        msg_buf.push_back(8'hA5);
        send_msg();
        // Short query that stops inside the flags word
        msg_buf = '{8'h12, 8'h34, 8'h56, 8'h78};
        send_msg();
        // Short query that covers the answer count but not the name
        msg_buf = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFE};
        send_msg();
        // Header only: ends right where the name would start
        add_header();
        send_msg();
        // Root name: zero first length, hash stays zero
        add_header();
        msg_buf.push_back(8'h00);
        msg_buf.push_back(8'h00);
        msg_buf.push_back(8'h01);
        msg_buf.push_back(8'h00);
        msg_buf.push_back(8'h01);
        send_msg();
        // Three labels with characters 0x00 and 0xFF, then type and class
        add_header();
        add_label(8'd3, 3);
        msg_buf.push_back(8'd1);
        msg_buf.push_back(8'h00);
        msg_buf.push_back(8'd1);
        msg_buf.push_back(8'hFF);
        msg_buf.push_back(8'h00);
        msg_buf.push_back(8'h00);
        msg_buf.push_back(8'h1C);
        msg_buf.push_back(8'h00);
        msg_buf.push_back(8'h01);
        send_msg();
        // Name cut off inside a label
        add_header();
        add_label(8'd5, 2);
        send_msg();
        // Length byte 0xC0 read as a plain count, name left unfinished
        add_header();
        add_label(8'hC0, 3);
        send_msg();
        wait_idle();
        flags_access(1'b0, 32'd0);

        // Random phases over several flag settings, extremes first
        set_flags(16'h0000);
        rand_phase();
        wait_idle();
        set_flags(16'hFFFF);
        rand_phase();
        wait_idle();
        set_flags(16'($urandom));
        // Final stretch runs at full rate on both sides
        stalls_on = 1'b0;
        rand_phase();
        wait_idle();
        repeat (20) @(negedge i_clk);

        $display("Covered %0d queries (%0d bytes in, %0d response bytes checked)",
                 n_queries, n_query_bytes, resp_checked);
        $display("Flags: reset value, all zeros, all ones, random; stalls then full rate");
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/dnsr_pkg.sv
hdl/dnsr_walk.sv
hdl/dnsr_out.sv
hdl/dns_query_to_answer_rewriter.sv
tb/dnsr_checker.sv
tb/tb_top.sv
